// ===== rtl/bgr420_pkg.sv =====
// Shared types, constants and register codes of the BGR to YCbCr 4:2:0 converter.
package bgr420_pkg;

	localparam int DEFAULT_MAX_WIDTH = 2048;
	localparam int HEIGHT_LIMIT      = 4096;

	// Compare widths for the clamped line width and frame height.
	localparam int WCMP_W = 14;
	localparam int HCMP_W = 13;
	localparam int ROW_W  = 12;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int LW_W       = 12;
	localparam int FH_W       = 13;

	localparam logic [LW_W-1:0] LINE_WIDTH_RESET   = 12'd320;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd240;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH   = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// Luma coefficients, 8-bit fixed point.
	localparam logic [15:0] Y_R      = 16'd66;
	localparam logic [15:0] Y_G      = 16'd129;
	localparam logic [15:0] Y_B      = 16'd25;
	localparam logic [7:0]  Y_OFFSET = 8'd16;

	// Chroma coefficients, 10-bit fixed point over 2x2 sums.
	localparam logic signed [7:0] CB_R = -8'sd38;
	localparam logic signed [7:0] CB_G = -8'sd74;
	localparam logic signed [7:0] CB_B = 8'sd112;
	localparam logic signed [7:0] CR_R = 8'sd112;
	localparam logic signed [7:0] CR_G = -8'sd94;
	localparam logic signed [7:0] CR_B = -8'sd18;

	localparam int CT_W = 19;
	// 128 << 10, so the offset and the floor division become one add and a shift.
	localparam logic signed [CT_W-1:0] CHROMA_BIAS = 19'sd131072;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [9:0] red;
		logic [9:0] green;
		logic [9:0] blue;
	} sums_t;

	typedef struct packed {
		logic chroma_valid;
		logic row_end;
	} flags_t;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
		logic       row_end;
	} result_t;

endpackage

// ===== rtl/bgr_to_ycbcr420_stream_converter_top.sv =====
// An item passes the stage 1, stage 2 and queue registers before it is offered.
// Throughput: one item per cycle; the input is ready while the output queue and the two
// arithmetic stages together hold fewer than four results.
// Reset is asynchronous and active low: counters, held pixel, pipeline and queue clear and
// the registers return to 320 by 240; the line store is not cleared.
// Top level of the BGR to YCbCr 4:2:0 stream converter.
module bgr_to_ycbcr420_stream_converter_top #(
	parameter int MAX_WIDTH = bgr420_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [23:0]                           s_tdata,  // blue, green, red
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [23:0]                           m_tdata,  // luma, chroma_blue, chroma_red
	output logic                                  m_tuser,  // chroma_valid
	output logic                                  m_tlast,
	input  logic                                  cfg_wr_en,
	input  logic [bgr420_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bgr420_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bgr420_pkg::*;

	localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
	localparam int AW    = CW - 1;
	localparam int DEPTH = (MAX_WIDTH + 1) / 2;

	rgb_t                  pix;
	logic                  acc;
	logic                  mem_we;
	logic                  mem_re;
	logic [AW-1:0]         mem_addr;
	sums_t                 mem_wdata;
	sums_t                 mem_rdata;
	logic                  valid_s1;
	rgb_t                  rgb_s1;
	sums_t                 sums_s1;
	flags_t                flags_s1;
	logic                  valid_s2;
	result_t               result;
	result_t               out_data;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [FIFO_CNT_W-1:0] occupancy;

	assign pix.blue  = s_tdata[7:0];
	assign pix.green = s_tdata[15:8];
	assign pix.red   = s_tdata[23:16];

	// Credit for every result still in flight, so a push never finds the queue full.
	assign occupancy = fifo_count + FIFO_CNT_W'(valid_s1) + FIFO_CNT_W'(valid_s2);
	assign s_tready  = occupancy < FIFO_CNT_W'(FIFO_DEPTH);
	assign acc       = s_tvalid & s_tready;

	bgr420_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.pix       (pix),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.valid_s1  (valid_s1),
		.rgb_s1    (rgb_s1),
		.sums_s1   (sums_s1),
		.flags_s1  (flags_s1)
	);

	// A write and a read of one entry are a row apart, so they never overlap.
	bgr420_line_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.re      (mem_re),
		.addr    (mem_addr),
		.wdata   (mem_wdata),
		.rdata_q (mem_rdata)
	);

	bgr420_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.rgb_s1   (rgb_s1),
		.sums_s1  (sums_s1),
		.flags_s1 (flags_s1),
		.rdata    (mem_rdata),
		.valid_s2 (valid_s2),
		.result   (result)
	);

	bgr420_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_data (result),
		.pop       (m_tready),
		.out_valid (m_tvalid),
		.out_data  (out_data),
		.count     (fifo_count)
	);

	assign m_tdata = {out_data.chroma_red, out_data.chroma_blue, out_data.luma};
	assign m_tuser = out_data.chroma_valid;
	assign m_tlast = out_data.row_end;

endmodule

// ===== rtl/bgr420_line_store.sv =====
// Line store of per-column-pair RGB sums, one write or one registered read per cycle.
module bgr420_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic                   re,
	input  logic [AW-1:0]          addr,
	input  bgr420_pkg::sums_t      wdata,
	output bgr420_pkg::sums_t      rdata_q
);
	import bgr420_pkg::*;

	sums_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

endmodule

// ===== rtl/bgr420_ctrl.sv =====
// Configuration registers, column and row counters, pair sums and line store access.
module bgr420_ctrl #(
	parameter int MAX_WIDTH = bgr420_pkg::DEFAULT_MAX_WIDTH,
	parameter int CW        = 11,
	parameter int AW        = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bgr420_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgr420_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           acc,
	input  bgr420_pkg::rgb_t               pix,
	output logic                           mem_we,
	output logic                           mem_re,
	output logic [AW-1:0]                  mem_addr,
	output bgr420_pkg::sums_t              mem_wdata,
	output logic                           valid_s1,
	output bgr420_pkg::rgb_t               rgb_s1,
	output bgr420_pkg::sums_t              sums_s1,
	output bgr420_pkg::flags_t             flags_s1
);
	import bgr420_pkg::*;

	logic [LW_W-1:0]   line_width_q;
	logic [FH_W-1:0]   frame_height_q;
	logic [CW-1:0]     col_q;
	logic [ROW_W-1:0]  row_q;
	rgb_t              held_q;

	logic [WCMP_W-1:0] lw_ext;
	logic [WCMP_W-1:0] weff;
	logic [HCMP_W-1:0] heff;
	logic              col_end;
	logic              row_wrap;
	flags_t            flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_LINE_WIDTH:   line_width_q   <= cfg_data[LW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		lw_ext = WCMP_W'(line_width_q);
		if (lw_ext == '0) begin
			weff = WCMP_W'(1);
		end else if (lw_ext > WCMP_W'(MAX_WIDTH)) begin
			weff = WCMP_W'(MAX_WIDTH);
		end else begin
			weff = lw_ext;
		end
		if (frame_height_q == '0) begin
			heff = HCMP_W'(1);
		end else if (frame_height_q > HCMP_W'(HEIGHT_LIMIT)) begin
			heff = HCMP_W'(HEIGHT_LIMIT);
		end else begin
			heff = frame_height_q;
		end
		col_end  = (WCMP_W'(col_q) + WCMP_W'(1)) >= weff;
		row_wrap = (HCMP_W'(row_q) + HCMP_W'(1)) >= heff;
	end

	// Odd columns close a pair: even rows store its sum, odd rows fetch the stored one.
	always_comb begin
		mem_wdata.red   = 10'(held_q.red) + 10'(pix.red);
		mem_wdata.green = 10'(held_q.green) + 10'(pix.green);
		mem_wdata.blue  = 10'(held_q.blue) + 10'(pix.blue);
		mem_addr        = col_q[CW-1:1];
		mem_we          = acc & col_q[0] & ~row_q[0];
		mem_re          = acc & col_q[0] & row_q[0];
		flags.chroma_valid = col_q[0] & row_q[0];
		flags.row_end      = col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			held_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				if (!col_q[0]) begin
					held_q <= pix;
				end
				if (col_end) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rgb_s1   <= pix;
			sums_s1  <= mem_wdata;
			flags_s1 <= flags;
		end
	end

endmodule

// ===== rtl/bgr420_calc.sv =====
// Luma and chroma arithmetic over two pipeline stages.
module bgr420_calc (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  bgr420_pkg::rgb_t      rgb_s1,
	input  bgr420_pkg::sums_t     sums_s1,
	input  bgr420_pkg::flags_t    flags_s1,
	input  bgr420_pkg::sums_t     rdata,
	output logic                  valid_s2,
	output bgr420_pkg::result_t   result
);
	import bgr420_pkg::*;

	logic [15:0]            ysum;
	logic [10:0]            tr;
	logic [10:0]            tg;
	logic [10:0]            tb;
	logic signed [CT_W-1:0] tr_s;
	logic signed [CT_W-1:0] tg_s;
	logic signed [CT_W-1:0] tb_s;
	logic signed [CT_W-1:0] tcb;
	logic signed [CT_W-1:0] tcr;
	logic signed [CT_W-1:0] bcb;
	logic signed [CT_W-1:0] bcr;

	logic [7:0]             luma_s2;
	logic signed [CT_W-1:0] tcb_s2;
	logic signed [CT_W-1:0] tcr_s2;
	flags_t                 flags_s2;

	always_comb begin
		ysum = Y_R * 16'(rgb_s1.red) + Y_G * 16'(rgb_s1.green) + Y_B * 16'(rgb_s1.blue);
		tr   = 11'(sums_s1.red) + 11'(rdata.red);
		tg   = 11'(sums_s1.green) + 11'(rdata.green);
		tb   = 11'(sums_s1.blue) + 11'(rdata.blue);
		tr_s = $signed({8'b0, tr});
		tg_s = $signed({8'b0, tg});
		tb_s = $signed({8'b0, tb});
		tcb  = CB_R * tr_s + CB_G * tg_s + CB_B * tb_s;
		tcr  = CR_R * tr_s + CR_G * tg_s + CR_B * tb_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			luma_s2  <= Y_OFFSET + ysum[15:8];
			tcb_s2   <= tcb;
			tcr_s2   <= tcr;
			flags_s2 <= flags_s1;
		end
	end

	// The biased value stays positive, so bits 17:10 give 128 plus the floored quotient.
	always_comb begin
		bcb                 = tcb_s2 + CHROMA_BIAS;
		bcr                 = tcr_s2 + CHROMA_BIAS;
		result.luma         = luma_s2;
		result.chroma_valid = flags_s2.chroma_valid;
		result.chroma_blue  = flags_s2.chroma_valid ? bcb[17:10] : 8'd0;
		result.chroma_red   = flags_s2.chroma_valid ? bcr[17:10] : 8'd0;
		result.row_end      = flags_s2.row_end;
	end

endmodule

// ===== rtl/bgr420_out_fifo.sv =====
// Small output queue that absorbs results while the downstream side stalls.
module bgr420_out_fifo (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	input  bgr420_pkg::result_t                   push_data,
	input  logic                                  pop,
	output logic                                  out_valid,
	output bgr420_pkg::result_t                   out_data,
	output logic [bgr420_pkg::FIFO_CNT_W-1:0]     count
);
	import bgr420_pkg::*;

	result_t               entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	assign out_valid = cnt_q != '0;
	assign out_data  = entry_q[rd_ptr_q];
	assign count     = cnt_q;
	assign do_pop    = pop & out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/bgr420_checker.sv =====
// Port-level assertions for the converter top level and the bind that attaches them.
module bgr420_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// Chroma fields are zero on items that do not complete a block.
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[23:8] == 16'd0)
		else $error("chroma given without chroma_valid");

	// Luma stays in limited range.
	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] >= 8'd16 && m_tdata[7:0] <= 8'd235)
		else $error("luma out of range");

	// No result can appear before an accepted item has passed through the pipeline or been queued.
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3) || $past(m_tvalid))
		else $error("result without accepted item");

endmodule

bind bgr_to_ycbcr420_stream_converter_top bgr420_checker u_bgr420_checker (.*);
